@@ rtl/cavlc_chroma_dc_residual_encoder_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the chroma DC residual encoder
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef CAVLC_CHROMA_DC_RESIDUAL_ENCODER_ASSERT_SVH
`define CAVLC_CHROMA_DC_RESIDUAL_ENCODER_ASSERT_SVH

// Same-cycle implication
`define CDRE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define CDRE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cdre_pkg.sv @@
// ----------------------------------------------------------------------------
// cdre_pkg
// Types, code tables and controller encodings of the chroma DC CAVLC encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cdre_pkg;

    localparam int unsigned MAX_COEFFS = 4;

    typedef struct packed {
        logic signed [11:0] coef_0;
        logic signed [11:0] coef_1;
        logic signed [11:0] coef_2;
        logic signed [11:0] coef_3;
    } in_item_t;

    typedef struct packed {
        logic [12:0] code_value;
        logic [4:0]  code_length;
        logic        last_word;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOKEN,
        ST_SIGN,
        ST_LEVEL,
        ST_TZ,
        ST_RUN
    } state_t;

    typedef enum logic [2:0] {
        WK_TOKEN,
        WK_SIGN,
        WK_LEVEL,
        WK_TZ,
        WK_RUN
    } word_kind_t;

    typedef struct packed {
        logic       load;
        logic       emit;
        word_kind_t kind;
        logic       last;
        logic       k_clr;
        logic       k_inc;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic tc_zero;
        logic t1_zero;
        logic sign_more;
        logic lev_more;
        logic full;
        logic run_start;
        logic run_more;
    } status_t;

    // coeff_token, nC = -1, [trailing ones][total coeff]
    localparam logic [4:0] TOK_LEN [4][5] = '{
        '{5'd2, 5'd6, 5'd6, 5'd6, 5'd6},
        '{5'd0, 5'd1, 5'd6, 5'd7, 5'd8},
        '{5'd0, 5'd0, 5'd3, 5'd7, 5'd8},
        '{5'd0, 5'd0, 5'd0, 5'd6, 5'd7}
    };
    localparam logic [2:0] TOK_CODE [4][5] = '{
        '{3'd1, 3'd7, 3'd4, 3'd3, 3'd2},
        '{3'd0, 3'd1, 3'd6, 3'd3, 3'd3},
        '{3'd0, 3'd0, 3'd1, 3'd2, 3'd2},
        '{3'd0, 3'd0, 3'd0, 3'd5, 3'd0}
    };

    // total_zeros, chroma DC 2x2, [total coeff - 1][total zeros]
    localparam logic [1:0] TZ_LEN [3][4] = '{
        '{2'd1, 2'd2, 2'd3, 2'd3},
        '{2'd1, 2'd2, 2'd2, 2'd0},
        '{2'd1, 2'd1, 2'd0, 2'd0}
    };
    localparam logic TZ_CODE [3][4] = '{
        '{1'b1, 1'b1, 1'b1, 1'b0},
        '{1'b1, 1'b1, 1'b0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 1'b0}
    };

    // run_before, [zeros left - 1][run]
    localparam logic [1:0] RB_LEN [3][4] = '{
        '{2'd1, 2'd1, 2'd0, 2'd0},
        '{2'd1, 2'd2, 2'd2, 2'd0},
        '{2'd2, 2'd2, 2'd2, 2'd2}
    };
    localparam logic [1:0] RB_CODE [3][4] = '{
        '{2'd1, 2'd0, 2'd0, 2'd0},
        '{2'd1, 2'd1, 2'd0, 2'd0},
        '{2'd3, 2'd2, 2'd1, 2'd0}
    };

endpackage

`default_nettype wire

@@ rtl/cavlc_chroma_dc_residual_encoder.sv @@
// One request carries the four chroma DC coefficients of a 2x2 block in scan
// order; the block answers with its CAVLC code words (coeff_token, trailing-one
// signs, levels, total_zeros, run_before), one word per result, the final one
// flagged by last_word. A block is loaded, then the sequencer emits one code word
// (1 to 7 words) per cycle into the output register while that register is free;
// with a stalled output the sequencer holds and the current word waits in the register.
// The next request is taken once the final word of a block is in the output
// register. Level magnitudes clamp to 2^(LEVEL_BITS-1)-1.
// ----------------------------------------------------------------------------
// cavlc_chroma_dc_residual_encoder
// Top level: controller and datapath of the chroma DC CAVLC encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module cavlc_chroma_dc_residual_encoder #(
    parameter int LEVEL_BITS = 12
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                     s_ready,
    input  wire cdre_pkg::in_item_t  s_payload,
    output logic                     m_valid,
    input  wire logic               m_ready,
    output cdre_pkg::out_item_t      m_payload
);

    cdre_pkg::cmd_t    cmd;
    cdre_pkg::status_t status;

    cdre_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cdre_datapath #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

`default_nettype wire

@@ rtl/cdre_datapath.sv @@
// ----------------------------------------------------------------------------
// cdre_datapath
// Holds the analyzed block, forms one code word per command, owns the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdre_datapath #(
    parameter int LEVEL_BITS = 12
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cdre_pkg::in_item_t s_payload,
    input  wire cdre_pkg::cmd_t     cmd,
    output cdre_pkg::status_t       status,
    output logic                    m_valid,
    input  wire logic              m_ready,
    output cdre_pkg::out_item_t     m_payload
);

    localparam logic signed [11:0] LevMax = 12'((1 << (LEVEL_BITS - 1)) - 1);

    logic signed [11:0] lev_reg [4];
    logic signed [11:0] lev_next [4];
    logic [1:0]         run_reg [4];
    logic [1:0]         run_next [4];
    logic [2:0]         tc_reg, tc_next;
    logic [1:0]         t1_reg, t1_next;
    logic [1:0]         tz_reg, tz_next;
    logic [1:0]         k_reg;
    logic [2:0]         sl_reg, sl_upd;
    logic [1:0]         zl_reg, zl_after;
    logic               m_valid_reg;
    cdre_pkg::out_item_t out_reg, word;

    // Analyze the block: saturate, collect levels highest index first, count
    always_comb begin
        logic signed [11:0] c;
        logic [2:0]         n;
        logic [1:0]         z;
        logic               run_on;
        n = 3'd0;
        z = 2'd0;
        for (int j = 0; j < 4; j++) begin
            lev_next[j] = 12'sd0;
            run_next[j] = 2'd0;
        end
        for (int i = 3; i >= 0; i--) begin
            case (i)
                3:       c = s_payload.coef_3;
                2:       c = s_payload.coef_2;
                1:       c = s_payload.coef_1;
                default: c = s_payload.coef_0;
            endcase
            if (c > LevMax) begin
                c = LevMax;
            end else if (c < -LevMax) begin
                c = -LevMax;
            end
            if (c != 12'sd0) begin
                lev_next[n[1:0]] = c;
                n = n + 3'd1;
            end else if (n != 3'd0) begin
                run_next[2'(n - 3'd1)] = run_next[2'(n - 3'd1)] + 2'd1;
                z = z + 2'd1;
            end
        end
        tc_next = n;
        tz_next = z;
        t1_next = 2'd0;
        run_on  = 1'b1;
        for (int k = 0; k < 3; k++) begin
            if (run_on && (3'(k) < n) &&
                (lev_next[k] == 12'sd1 || lev_next[k] == -12'sd1)) begin
                t1_next = t1_next + 2'd1;
            end else begin
                run_on = 1'b0;
            end
        end
    end

    // Level code word for the current index
    logic signed [11:0] lv;
    logic               neg;
    logic [10:0]        mag, sl_lim;
    logic [11:0]        lc_base, lc;
    logic [10:0]        thr;
    logic [12:0]        lev_val;
    logic [4:0]         lev_len;
    logic [2:0]         sl_one;

    always_comb begin
        lv      = lev_reg[k_reg];
        neg     = lv[11];
        mag     = neg ? 11'(-lv) : lv[10:0];
        lc_base = {mag - 11'd1, neg};
        lc      = (k_reg == t1_reg && t1_reg != 2'd3) ? lc_base - 12'd2 : lc_base;
        thr     = 11'(11'd15 << sl_reg);
        if (sl_reg == 3'd0) begin
            if (lc < 12'd14) begin
                lev_len = 5'(lc + 12'd1);
                lev_val = 13'd1;
            end else if (lc < 12'd30) begin
                lev_len = 5'd19;
                lev_val = 13'(12'd16 + (lc - 12'd14));
            end else begin
                lev_len = 5'd28;
                lev_val = {1'b1, 12'(lc - 12'd30)};
            end
        end else if (lc < {1'b0, thr}) begin
            lev_len = 5'((lc >> sl_reg) + 12'(sl_reg) + 12'd1);
            lev_val = (13'd1 << sl_reg) | (13'(lc) & ((13'd1 << sl_reg) - 13'd1));
        end else begin
            lev_len = 5'd28;
            lev_val = {1'b1, 12'(lc - {1'b0, thr})};
        end
        // Adapt suffix length after this level
        sl_one = (sl_reg == 3'd0) ? 3'd1 : sl_reg;
        sl_lim = 11'(11'd3 << (sl_one - 3'd1));
        sl_upd = (mag > sl_lim && sl_one < 3'd6) ? sl_one + 3'd1 : sl_one;
    end

    // Select the word for the current step
    always_comb begin
        logic [1:0] row;
        row  = zl_reg - 2'd1;
        word = '0;
        word.last_word = cmd.last;
        case (cmd.kind)
            cdre_pkg::WK_TOKEN: begin
                word.code_value  = 13'(cdre_pkg::TOK_CODE[t1_reg][tc_reg]);
                word.code_length = cdre_pkg::TOK_LEN[t1_reg][tc_reg];
            end
            cdre_pkg::WK_SIGN: begin
                word.code_value  = 13'(lv[11]);
                word.code_length = 5'd1;
            end
            cdre_pkg::WK_LEVEL: begin
                word.code_value  = lev_val;
                word.code_length = lev_len;
            end
            cdre_pkg::WK_TZ: begin
                word.code_value  = 13'(cdre_pkg::TZ_CODE[2'(tc_reg - 3'd1)][tz_reg]);
                word.code_length = 5'(cdre_pkg::TZ_LEN[2'(tc_reg - 3'd1)][tz_reg]);
            end
            cdre_pkg::WK_RUN: begin
                word.code_value  = 13'(cdre_pkg::RB_CODE[row][run_reg[k_reg]]);
                word.code_length = 5'(cdre_pkg::RB_LEN[row][run_reg[k_reg]]);
            end
            default: begin
                word.code_value  = 13'd0;
                word.code_length = 5'd0;
            end
        endcase
    end

    assign zl_after = zl_reg - run_reg[k_reg];

    // Status toward the controller
    always_comb begin
        status.out_free  = !m_valid_reg || m_ready;
        status.tc_zero   = (tc_reg == 3'd0);
        status.t1_zero   = (t1_reg == 2'd0);
        status.sign_more = ({1'b0, k_reg} + 3'd1) < {1'b0, t1_reg};
        status.lev_more  = ({1'b0, k_reg} + 3'd1) < tc_reg;
        status.full      = (tc_reg == 3'(cdre_pkg::MAX_COEFFS));
        status.run_start = (tz_reg != 2'd0) && (tc_reg > 3'd1);
        status.run_more  = (({1'b0, k_reg} + 3'd2) < tc_reg) && (zl_after != 2'd0);
    end

    // Block registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            lev_reg <= lev_next;
            run_reg <= run_next;
            tc_reg  <= tc_next;
            t1_reg  <= t1_next;
            tz_reg  <= tz_next;
            zl_reg  <= tz_next;
            sl_reg  <= 3'd0;
            k_reg   <= 2'd0;
        end else if (cmd.emit) begin
            if (cmd.kind == cdre_pkg::WK_LEVEL) begin
                sl_reg <= sl_upd;
            end
            if (cmd.kind == cdre_pkg::WK_RUN) begin
                zl_reg <= zl_after;
            end
            if (cmd.k_clr) begin
                k_reg <= 2'd0;
            end else if (cmd.k_inc) begin
                k_reg <= k_reg + 2'd1;
            end
        end
    end

    // Output register: load on emit, drop on acceptance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_reg <= word;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

endmodule

`default_nettype wire

@@ rtl/cdre_ctrl.sv @@
// ----------------------------------------------------------------------------
// cdre_ctrl
// Sequencer: walks token, signs, levels, total_zeros and runs, one code word
// per step.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cavlc_chroma_dc_residual_encoder_assert.svh"

module cdre_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                    s_ready,
    input  wire cdre_pkg::status_t  status,
    output cdre_pkg::cmd_t          cmd
);

    cdre_pkg::state_t state_reg, state_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cdre_pkg::ST_IDLE: begin
                if (s_valid) state_next = cdre_pkg::ST_TOKEN;
            end
            cdre_pkg::ST_TOKEN: begin
                if (status.out_free) begin
                    if (status.tc_zero)      state_next = cdre_pkg::ST_IDLE;
                    else if (status.t1_zero) state_next = cdre_pkg::ST_LEVEL;
                    else                     state_next = cdre_pkg::ST_SIGN;
                end
            end
            cdre_pkg::ST_SIGN: begin
                if (status.out_free) begin
                    if (status.sign_more)     state_next = cdre_pkg::ST_SIGN;
                    else if (status.lev_more) state_next = cdre_pkg::ST_LEVEL;
                    else if (status.full)     state_next = cdre_pkg::ST_IDLE;
                    else                      state_next = cdre_pkg::ST_TZ;
                end
            end
            cdre_pkg::ST_LEVEL: begin
                if (status.out_free) begin
                    if (status.lev_more)  state_next = cdre_pkg::ST_LEVEL;
                    else if (status.full) state_next = cdre_pkg::ST_IDLE;
                    else                  state_next = cdre_pkg::ST_TZ;
                end
            end
            cdre_pkg::ST_TZ: begin
                if (status.out_free) begin
                    state_next = status.run_start ? cdre_pkg::ST_RUN : cdre_pkg::ST_IDLE;
                end
            end
            cdre_pkg::ST_RUN: begin
                if (status.out_free) begin
                    state_next = status.run_more ? cdre_pkg::ST_RUN : cdre_pkg::ST_IDLE;
                end
            end
            default: state_next = cdre_pkg::ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        cmd      = '0;
        cmd.kind = cdre_pkg::WK_TOKEN;
        s_ready  = 1'b0;
        case (state_reg)
            cdre_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            cdre_pkg::ST_TOKEN: begin
                cmd.emit  = status.out_free;
                cmd.last  = status.tc_zero;
                cmd.k_clr = 1'b1;
            end
            cdre_pkg::ST_SIGN: begin
                cmd.kind  = cdre_pkg::WK_SIGN;
                cmd.emit  = status.out_free;
                cmd.last  = !status.sign_more && !status.lev_more && status.full;
                cmd.k_inc = 1'b1;
            end
            cdre_pkg::ST_LEVEL: begin
                cmd.kind  = cdre_pkg::WK_LEVEL;
                cmd.emit  = status.out_free;
                cmd.last  = !status.lev_more && status.full;
                cmd.k_inc = 1'b1;
            end
            cdre_pkg::ST_TZ: begin
                cmd.kind  = cdre_pkg::WK_TZ;
                cmd.emit  = status.out_free;
                cmd.last  = !status.run_start;
                cmd.k_clr = 1'b1;
            end
            cdre_pkg::ST_RUN: begin
                cmd.kind  = cdre_pkg::WK_RUN;
                cmd.emit  = status.out_free;
                cmd.last  = !status.run_more;
                cmd.k_inc = 1'b1;
            end
            default: begin
                cmd.kind = cdre_pkg::WK_TOKEN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cdre_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `CDRE_ASSERT_NOW(a_emit_free, aclk, aresetn, cmd.emit, status.out_free, "emit into busy slot")
    `CDRE_ASSERT_NEXT(a_req_token, aclk, aresetn, s_valid && s_ready, state_reg == cdre_pkg::ST_TOKEN, "request not followed by token")
    `CDRE_ASSERT_NEXT(a_last_idle, aclk, aresetn, cmd.emit && cmd.last, state_reg == cdre_pkg::ST_IDLE, "last word not ending block")
    `CDRE_ASSERT_NOW(a_idle_quiet, aclk, aresetn, state_reg == cdre_pkg::ST_IDLE, !cmd.emit, "emit while idle")

endmodule

`default_nettype wire

@@ tb/sv/tb_cavlc_chroma_dc_residual_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chroma DC CAVLC encoder testbench
// Sends 2x2 chroma DC blocks through the encoder and checks every code word
// (value, length, last flag) against an in-bench CAVLC coder. Directed blocks
// come first, then random blocks biased toward small levels, ones and zeros.
// ----------------------------------------------------------------------------

module tb_cavlc_chroma_dc_residual_encoder;

    localparam int NUM_RANDOM  = 390;
    localparam int STALL_LIMIT = 2000;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    cdre_pkg::in_item_t  s_payload = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    cdre_pkg::out_item_t m_payload;

    cdre_pkg::out_item_t code_words_pending[$];
    int        fail_count = 0;
    int        words_seen = 0;
    int        requests_sent = 0;
    int        idle_cycles = 0;
    bit        calm_phase = 1'b0;

    // one directed row: coefficients plus, where known by hand, the words
    typedef struct {
        logic signed [11:0]  c[4];
        int                  n_known;
        cdre_pkg::out_item_t known[2];
    } dir_row_t;

    cavlc_chroma_dc_residual_encoder dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload)
    );

    always #5 aclk = ~aclk;

    // Code-word predictor for one block
    function automatic void encode_block(input cdre_pkg::in_item_t blk,
                                         output cdre_pkg::out_item_t words[$]);
        logic signed [11:0] raw[4];
        int c[4], lev[4], run[4];
        int tc, t1, tz, mag, lc, len, val, sl, zl, row, k, tlen, tcode;
        int tzlen[3][4], tzcode[3][4], rblen[3][4], rbcode[3][4];
        cdre_pkg::out_item_t w;
        words = {};
        raw = '{blk.coef_0, blk.coef_1, blk.coef_2, blk.coef_3};
        tzlen  = '{'{1,2,3,3}, '{1,2,2,0}, '{1,1,0,0}};
        tzcode = '{'{1,1,1,0}, '{1,1,0,0}, '{1,0,0,0}};
        rblen  = '{'{1,1,0,0}, '{1,2,2,0}, '{2,2,2,2}};
        rbcode = '{'{1,0,0,0}, '{1,1,0,0}, '{3,2,1,0}};
        tc = 0; t1 = 0; tz = 0;
        for (int i = 0; i < 4; i++) begin
            c[i] = raw[i];
            if (c[i] < -2047) c[i] = -2047;
        end
        for (int i = 3; i >= 0; i--) begin
            if (c[i] != 0) begin
                lev[tc] = c[i]; run[tc] = 0; tc++;
            end else if (tc > 0) begin
                run[tc-1]++; tz++;
            end
        end
        while (t1 < tc && t1 < 3 && (lev[t1] == 1 || lev[t1] == -1)) t1++;
        // coeff_token, nC = -1
        case ({t1[1:0], tc[2:0]})
            5'b00_000: begin tlen = 2; tcode = 1; end
            5'b00_001: begin tlen = 6; tcode = 7; end
            5'b00_010: begin tlen = 6; tcode = 4; end
            5'b00_011: begin tlen = 6; tcode = 3; end
            5'b00_100: begin tlen = 6; tcode = 2; end
            5'b01_001: begin tlen = 1; tcode = 1; end
            5'b01_010: begin tlen = 6; tcode = 6; end
            5'b01_011: begin tlen = 7; tcode = 3; end
            5'b01_100: begin tlen = 8; tcode = 3; end
            5'b10_010: begin tlen = 3; tcode = 1; end
            5'b10_011: begin tlen = 7; tcode = 2; end
            5'b10_100: begin tlen = 8; tcode = 2; end
            5'b11_011: begin tlen = 6; tcode = 5; end
            default:   begin tlen = 7; tcode = 0; end
        endcase
        w = '{code_value: 13'(tcode), code_length: 5'(tlen), last_word: 1'b0};
        words.push_back(w);
        if (tc > 0) begin
            for (k = 0; k < t1; k++) begin
                w = '{code_value: (lev[k] < 0) ? 13'd1 : 13'd0, code_length: 5'd1,
                      last_word: 1'b0};
                words.push_back(w);
            end
            sl = 0;
            for (k = t1; k < tc; k++) begin
                mag = (lev[k] < 0) ? -lev[k] : lev[k];
                lc = 2 * (mag - 1) + ((lev[k] < 0) ? 1 : 0);
                if (k == t1 && t1 < 3) lc -= 2;
                if (sl == 0) begin
                    if (lc < 14) begin len = lc + 1; val = 1; end
                    else if (lc < 30) begin len = 19; val = 16 | (lc - 14); end
                    else begin len = 28; val = 4096 | ((lc - 30) & 12'hFFF); end
                end else if (lc < (15 << sl)) begin
                    len = (lc >> sl) + 1 + sl;
                    val = (1 << sl) | (lc & ((1 << sl) - 1));
                end else begin
                    len = 28; val = 4096 | ((lc - (15 << sl)) & 12'hFFF);
                end
                w = '{code_value: 13'(val), code_length: 5'(len), last_word: 1'b0};
                words.push_back(w);
                if (sl == 0) sl = 1;
                if (mag > (3 << (sl - 1)) && sl < 6) sl++;
            end
            if (tc < 4) begin
                zl = tz;
                w = '{code_value: 13'(tzcode[tc-1][tz]), code_length: 5'(tzlen[tc-1][tz]),
                      last_word: 1'b0};
                words.push_back(w);
                for (k = 0; k + 1 < tc && zl > 0; k++) begin
                    row = ((zl > 3) ? 3 : zl) - 1;
                    w = '{code_value: 13'(rbcode[row][run[k]]),
                          code_length: 5'(rblen[row][run[k]]), last_word: 1'b0};
                    words.push_back(w);
                    zl -= run[k];
                end
            end
        end
        words[words.size()-1].last_word = 1'b1;
    endfunction

    // Pick one coefficient, mostly small, sometimes extreme or zero
    function automatic logic signed [11:0] pick_coef();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30) return 12'sd0;
        if (sel < 55) return $urandom_range(0, 1) ? 12'sd1 : -12'sd1;
        if (sel < 75) return 12'($signed($urandom_range(0, 8)) - 4);
        if (sel < 88) return 12'($signed($urandom_range(0, 80)) - 40);
        if (sel < 93) return $urandom_range(0, 1) ? 12'sd2047 : 12'h800;
        return 12'($urandom);
    endfunction

    // Send one request and queue its predicted words; valid stays up between
    // back-to-back requests and drops only while the sender idles
    task automatic send_block(input cdre_pkg::in_item_t blk);
        cdre_pkg::out_item_t words[$];
        encode_block(blk, words);
        while (!calm_phase && $urandom_range(0, 99) < 21) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        foreach (words[i]) code_words_pending.push_back(words[i]);
        s_payload <= blk;
        s_valid   <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
        @(negedge aclk);
    endtask

    // Randomly stall the result side, except during the calm stretch
    always @(negedge aclk) begin
        m_ready <= calm_phase ? 1'b1 : ($urandom_range(0, 99) >= 21);
    end

    // Compare each accepted word against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            words_seen++;
            if (code_words_pending.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected word value=%0h len=%0d last=%0b", $realtime,
                         m_payload.code_value, m_payload.code_length, m_payload.last_word);
            end else begin
                cdre_pkg::out_item_t exp_w;
                exp_w = code_words_pending.pop_front();
                if (m_payload.code_value !== exp_w.code_value) begin
                    fail_count++;
                    $display("%0t: code_value expected %0h actual %0h", $realtime,
                             exp_w.code_value, m_payload.code_value);
                end
                if (m_payload.code_length !== exp_w.code_length) begin
                    fail_count++;
                    $display("%0t: code_length expected %0d actual %0d", $realtime,
                             exp_w.code_length, m_payload.code_length);
                end
                if (m_payload.last_word !== exp_w.last_word) begin
                    fail_count++;
                    $display("%0t: last_word expected %0b actual %0b", $realtime,
                             exp_w.last_word, m_payload.last_word);
                end
            end
        end
    end

    // Watchdog: count cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        dir_row_t            rows[$];
        dir_row_t            r;
        cdre_pkg::in_item_t  blk;
        cdre_pkg::out_item_t words[$];
        int                  wait_cycles;

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed blocks; hand-typed words for the all-zero and lone-one cases
        r.n_known = 1; r.known[0] = '{code_value: 13'd1, code_length: 5'd2, last_word: 1'b1};
        r.c = '{0, 0, 0, 0}; rows.push_back(r);
        r.n_known = 2;
        r.known[0] = '{code_value: 13'd1, code_length: 5'd1, last_word: 1'b0};
        r.known[1] = '{code_value: 13'd0, code_length: 5'd1, last_word: 1'b0};
        r.c = '{0, 0, 0, 1}; rows.push_back(r);
        r.n_known = 0;
        r.c = '{1, 0, 0, 0};            rows.push_back(r);
        r.c = '{-1, 1, -1, 1};          rows.push_back(r);
        r.c = '{2047, 2047, 2047, 2047}; rows.push_back(r);
        r.c = '{-2048, -2047, -2048, 0}; rows.push_back(r);
        r.c = '{12'sh800, 0, 0, 0};     rows.push_back(r);
        r.c = '{0, 2047, 0, 0};         rows.push_back(r);
        r.c = '{5, 0, 0, -1};           rows.push_back(r);
        r.c = '{0, 1, 0, 1};            rows.push_back(r);
        r.c = '{1, 0, 1, 0};            rows.push_back(r);
        r.c = '{-3, 2, 0, 0};           rows.push_back(r);
        r.c = '{8, -9, 15, 16};         rows.push_back(r);
        r.c = '{0, 0, 2, 0};            rows.push_back(r);
        r.c = '{0, 0, -8, -9};          rows.push_back(r);
        r.c = '{100, -200, 400, -800};  rows.push_back(r);
        r.c = '{1, 1, 1, 2};            rows.push_back(r);
        r.c = '{-2, 1, 1, 1};           rows.push_back(r);
        r.c = '{3, 0, 4, 0};            rows.push_back(r);
        r.c = '{-1, -1, 0, 0};          rows.push_back(r);
        foreach (rows[i]) begin
            blk = '{coef_0: rows[i].c[0], coef_1: rows[i].c[1],
                    coef_2: rows[i].c[2], coef_3: rows[i].c[3]};
            if (rows[i].n_known > 0) begin
                encode_block(blk, words);
                for (int j = 0; j < rows[i].n_known; j++) begin
                    if (j >= words.size()) begin
                        fail_count++;
                        $display("%0t: row %0d word %0d expected %p actual none",
                                 $realtime, i, j, rows[i].known[j]);
                    end else if (words[j] !== rows[i].known[j]) begin
                        fail_count++;
                        $display("%0t: row %0d word %0d expected %p actual %p",
                                 $realtime, i, j, rows[i].known[j], words[j]);
                    end
                end
            end
            send_block(blk);
        end

        // Random blocks; hold the sender once until the output drains
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == NUM_RANDOM / 2) begin
                s_valid <= 1'b0;
                do @(negedge aclk); while (code_words_pending.size() != 0);
            end
            calm_phase = (n >= 100 && n < 160);
            blk = '{coef_0: pick_coef(), coef_1: pick_coef(),
                    coef_2: pick_coef(), coef_3: pick_coef()};
            send_block(blk);
        end
        calm_phase = 1'b0;
        s_valid <= 1'b0;

        // Drain, then keep watching for stray words
        wait_cycles = 0;
        while (code_words_pending.size() != 0 && wait_cycles < 20000) begin
            @(negedge aclk);
            wait_cycles++;
        end
        repeat (30) @(negedge aclk);

        $display("Encoded %0d chroma DC blocks, checked %0d code words.",
                 requests_sent, words_seen);
        if (fail_count == 0 && code_words_pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ cavlc_chroma_dc_residual_encoder.f @@
+incdir+rtl
rtl/cdre_pkg.sv
rtl/cdre_datapath.sv
rtl/cdre_ctrl.sv
rtl/cavlc_chroma_dc_residual_encoder.sv
tb/sv/tb_cavlc_chroma_dc_residual_encoder.sv
